@@ sv/sfck_pkg.sv @@
// ============================================================================
// sfck_pkg
// Shared types, constants and helpers for the scaled fast clock keeper.
// ============================================================================
package sfck_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SYNC  = 2'd1,
        CMD_FOLD  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_HOLD = 2'd1,
        DISP_FAST = 2'd2,
        DISP_REAL = 2'd3
    } disp_t;

    typedef enum logic [1:0] {
        MER_24H = 2'd0,
        MER_AM  = 2'd1,
        MER_PM  = 2'd2
    } mer_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    // bit0 show fast, bit1 hold, bit2 fast 12h, bit3 real 12h
    typedef struct packed {
        logic real12;
        logic fast12;
        logic hold;
        logic fast;
    } mode_t;

    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int HALF_DAY      = 12;
    localparam int DECI_PER_SEC  = 10;
    localparam int CARRY_LIMIT   = 10;

    // x / 10 = (x * RECIP_10) >> 19, exact for 16 bit x
    localparam int RECIP_10        = 52429;
    localparam int RECIP_10_SHIFT  = 19;
    // x / 100 = (x * RECIP_100) >> 23, exact for 16 bit x
    localparam int RECIP_100       = 83887;
    localparam int RECIP_100_SHIFT = 23;
    // x / 60 = (x * RECIP_60) >> 19, exact for x below 10082
    localparam int RECIP_60        = 8739;
    localparam int RECIP_60_SHIFT  = 19;

    // 65536 = 6553 * 10 + 6: wrap point of the pending decisecond count
    localparam int PEND_WRAP_Q = 6553;
    localparam int PEND_WRAP_R = 6;

    localparam logic [7:0] TIMEOUT_RESET  = 8'd150;
    localparam logic [7:0] TO_DIRECT_MAX  = 8'd250;
    localparam logic [7:0] TO_CODE_30S    = 8'd251;
    localparam logic [7:0] TO_CODE_60S    = 8'd252;
    localparam logic [7:0] TO_CODE_90S    = 8'd253;
    localparam logic [7:0] TO_CODE_120S   = 8'd254;
    localparam logic [10:0] TO_LOAD_30S   = 11'd300;
    localparam logic [10:0] TO_LOAD_60S   = 11'd600;
    localparam logic [10:0] TO_LOAD_90S   = 11'd900;
    localparam logic [10:0] TO_LOAD_120S  = 11'd1200;

    function automatic logic [10:0] timeout_load(input logic [7:0] code);
        logic [10:0] load;
        if (code <= TO_DIRECT_MAX) begin
            load = {3'd0, code};
        end else begin
            case (code)
                TO_CODE_30S:  load = TO_LOAD_30S;
                TO_CODE_60S:  load = TO_LOAD_60S;
                TO_CODE_90S:  load = TO_LOAD_90S;
                TO_CODE_120S: load = TO_LOAD_120S;
                default:      load = 11'd0;
            endcase
        end
        return load;
    endfunction

endpackage

@@ sv/sfck_fold.sv @@
// ============================================================================
// sfck_fold
// Adds whole seconds to a time of day, carrying into minutes and hours mod 24.
// ============================================================================
module sfck_fold (
    input  sfck_pkg::hms_t cur_hms,
    input  logic [12:0]    add_secs,
    output sfck_pkg::hms_t new_hms
);
    import sfck_pkg::*;

    logic [12:0] sec_sum;
    logic [26:0] sec_prod;
    logic [6:0]  min_carry;
    logic [12:0] carry_x60;
    logic [12:0] sec_left;
    logic [7:0]  min_sum;
    logic [5:0]  min_left;
    logic [1:0]  hour_carry;
    logic [5:0]  hour_sum;

    // seconds plus add stays below 6617
    assign sec_sum   = {7'd0, cur_hms.seconds} + add_secs;
    assign sec_prod  = {14'd0, sec_sum} * 27'(RECIP_60);
    assign min_carry = 7'(sec_prod >> RECIP_60_SHIFT);
    assign carry_x60 = {6'd0, min_carry} * 13'(SEC_PER_MIN);
    assign sec_left  = sec_sum - carry_x60;
    assign min_sum   = {2'd0, cur_hms.minutes} + {1'b0, min_carry};

    // minute sum is at most 173, so at most two hours carry
    always_comb begin
        if (min_sum >= 8'(2 * MIN_PER_HOUR)) begin
            min_left   = 6'(min_sum - 8'(2 * MIN_PER_HOUR));
            hour_carry = 2'd2;
        end else if (min_sum >= 8'(MIN_PER_HOUR)) begin
            min_left   = 6'(min_sum - 8'(MIN_PER_HOUR));
            hour_carry = 2'd1;
        end else begin
            min_left   = min_sum[5:0];
            hour_carry = 2'd0;
        end
    end

    assign hour_sum = {1'b0, cur_hms.hours} + {4'd0, hour_carry};

    always_comb begin
        new_hms.seconds = sec_left[5:0];
        new_hms.minutes = min_left;
        if (hour_sum >= 6'(HOURS_PER_DAY)) begin
            new_hms.hours = 5'(hour_sum - 6'(HOURS_PER_DAY));
        end else begin
            new_hms.hours = hour_sum[4:0];
        end
    end

endmodule

@@ sv/sfck_display.sv @@
// ============================================================================
// sfck_display
// Picks the shown clock and formats its hour in 12 or 24 hour form.
// ============================================================================
module sfck_display (
    input  sfck_pkg::mode_t mode,
    input  sfck_pkg::hms_t  real_hms,
    input  sfck_pkg::hms_t  fast_hms,
    input  logic [10:0]     countdown,
    output sfck_pkg::disp_t state,
    output logic [4:0]      hour,
    output logic [5:0]      minute,
    output sfck_pkg::mer_t  mer
);
    import sfck_pkg::*;

    hms_t       sel_hms;
    logic       twelve;
    logic [4:0] h;

    assign sel_hms = mode.fast ? fast_hms : real_hms;
    assign twelve  = mode.fast ? mode.fast12 : mode.real12;
    assign h       = sel_hms.hours;

    always_comb begin
        state  = DISP_NONE;
        hour   = 5'd0;
        minute = 6'd0;
        mer    = MER_24H;
        if (countdown == 11'd0) begin
            state = DISP_NONE;
        end else if (mode.fast && mode.hold) begin
            state = DISP_HOLD;
        end else begin
            state  = mode.fast ? DISP_FAST : DISP_REAL;
            minute = sel_hms.minutes;
            if (twelve) begin
                if (h == 5'd0) begin
                    hour = 5'(HALF_DAY);
                end else if (h > 5'(HALF_DAY)) begin
                    hour = 5'(h - 5'(HALF_DAY));
                end else begin
                    hour = h;
                end
                mer = (h >= 5'(HALF_DAY)) ? MER_PM : MER_AM;
            end else begin
                hour = h;
            end
        end
    end

endmodule

@@ sv/scaled_fast_clock_keeper.sv @@
// ============================================================================
// scaled_fast_clock_keeper
// Keeps a real and a scaled fast time of day, synced from time packets.
//
// Each request on the s_ side carries a command in s_tuser: a 10 Hz tick, a
// time packet sync, a fold of accumulated fast seconds, or a clear of
// validity. Every request produces exactly one result on the m_ side: the
// display state and the hour/minute to show (12 or 24 hour form) plus the
// remaining dead reckoning time. The block takes one request per clock
// unless a held result stalls it. A request waits in the input register
// until the result register can load; while m_tready stays low a held
// result keeps the request in the input register and s_tready drops. The
// shared clock state is updated in the same cycle as the result register,
// so each request sees the effect of the one before it. The ratio is split
// into hundreds, tens and units of tenths at sync time so ticks need only
// adds; pending deciseconds are held as whole seconds plus a 0..9 remainder
// so a fold is one add chain. The user writes timeout_code through
// cfg_we/cfg_wdata only while idle; the block does not enforce this.
// ============================================================================
module scaled_fast_clock_keeper (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // timeout_code

    input  logic        s_tvalid,
    output logic        s_tready,
    // real_hours[4:0], real_minutes[10:5], real_seconds[16:11],
    // mode_flags[20:17], fast_hours[25:21], fast_minutes[31:26],
    // fast_seconds[37:32], scale_factor[53:38], zero pad[55:54]
    input  logic [55:0] s_tdata,
    // cmd[1:0], has_fast_section[2]
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // shown_hour[4:0], shown_minute[10:5], meridiem[12:11], valid_left[23:13]
    output logic [23:0] m_tdata,
    // display_state[1:0]
    output logic [1:0]  m_tuser
);
    import sfck_pkg::*;

    // ---------------------------------------------------------------- input
    logic        in_valid_reg;
    logic [53:0] in_data_reg;
    logic [2:0]  in_user_reg;
    logic        advance;

    // ----------------------------------------------------------- clock state
    logic [7:0]  timeout_reg;
    hms_t        real_hms_reg,  real_hms_next;
    hms_t        fast_hms_reg,  fast_hms_next;
    mode_t       mode_reg,      mode_next;
    logic [9:0]  ratio_hund_reg, ratio_hund_next;   // ratio / 100
    logic [3:0]  ratio_dec_reg,  ratio_dec_next;    // (ratio / 10) % 10
    logic [3:0]  ratio_unit_reg, ratio_unit_next;   // ratio % 10
    logic [12:0] pend_q_reg,    pend_q_next;        // pending / 10
    logic [3:0]  pend_r_reg,    pend_r_next;        // pending % 10
    logic [4:0]  carry_reg,     carry_next;
    logic [10:0] countdown_reg, countdown_next;

    // --------------------------------------------------------------- output
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // ------------------------------------------------------- request fields
    cmd_t        in_cmd;
    logic        in_has_fast;
    hms_t        in_real_hms;
    hms_t        in_fast_hms;
    mode_t       in_mode;
    logic [15:0] in_scale;

    assign in_cmd      = cmd_t'(in_user_reg[1:0]);
    assign in_has_fast = in_user_reg[2];
    assign in_real_hms = '{hours: in_data_reg[4:0], minutes: in_data_reg[10:5],
                           seconds: in_data_reg[16:11]};
    assign in_mode     = mode_t'(in_data_reg[20:17]);
    assign in_fast_hms = '{hours: in_data_reg[25:21], minutes: in_data_reg[31:26],
                           seconds: in_data_reg[37:32]};
    assign in_scale    = in_data_reg[53:38];

    // Handshake: input register refills while the result register drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // ------------------------------------------------- ratio split on sync
    logic [32:0] scale_prod100;
    logic [31:0] scale_prod10;
    logic [9:0]  scale_hund;
    logic [12:0] scale_tens;
    logic [15:0] scale_tens_x10;
    logic [12:0] scale_hund_x10;
    logic [15:0] scale_unit;
    logic [12:0] scale_dec;

    assign scale_prod100  = {17'd0, in_scale} * 33'(RECIP_100);
    assign scale_prod10   = {16'd0, in_scale} * 32'(RECIP_10);
    assign scale_hund     = 10'(scale_prod100 >> RECIP_100_SHIFT);
    assign scale_tens     = 13'(scale_prod10 >> RECIP_10_SHIFT);
    assign scale_tens_x10 = {3'd0, scale_tens} * 16'(DECI_PER_SEC);
    assign scale_hund_x10 = {3'd0, scale_hund} * 13'(DECI_PER_SEC);
    assign scale_unit     = in_scale - scale_tens_x10;
    assign scale_dec      = scale_tens - scale_hund_x10;

    // ------------------------------------------------------ tick accumulate
    logic        fast_running;
    logic [4:0]  carry_sum;
    logic        carry_out;
    logic [4:0]  carry_left;
    logic [4:0]  rem_sum;
    logic        rem_hi;
    logic [3:0]  rem_adj;
    logic [12:0] quo_sum;
    logic        pend_wrap;
    logic [12:0] tick_q;
    logic [3:0]  tick_r;

    assign fast_running = mode_reg.fast && !mode_reg.hold;

    // fractional tenths are released only when strictly above ten
    assign carry_sum  = carry_reg + {1'b0, ratio_unit_reg};
    assign carry_out  = carry_sum > 5'(CARRY_LIMIT);
    assign carry_left = carry_out ? 5'(carry_sum - 5'(CARRY_LIMIT)) : carry_sum;

    assign rem_sum = {1'b0, pend_r_reg} + {1'b0, ratio_dec_reg} + {4'd0, carry_out};
    assign rem_hi  = rem_sum >= 5'(DECI_PER_SEC);
    assign rem_adj = rem_hi ? 4'(rem_sum - 5'(DECI_PER_SEC)) : rem_sum[3:0];
    assign quo_sum = pend_q_reg + {3'd0, ratio_hund_reg} + {12'd0, rem_hi};

    // pending count wraps modulo 65536
    assign pend_wrap = (quo_sum > 13'(PEND_WRAP_Q)) ||
                       ((quo_sum == 13'(PEND_WRAP_Q)) && (rem_adj >= 4'(PEND_WRAP_R)));

    always_comb begin
        tick_q = quo_sum;
        tick_r = rem_adj;
        if (pend_wrap) begin
            if (rem_adj >= 4'(PEND_WRAP_R)) begin
                tick_q = 13'(quo_sum - 13'(PEND_WRAP_Q));
                tick_r = 4'(rem_adj - 4'(PEND_WRAP_R));
            end else begin
                tick_q = 13'(quo_sum - 13'(PEND_WRAP_Q + 1));
                tick_r = 4'(rem_adj + 4'(DECI_PER_SEC - PEND_WRAP_R));
            end
        end
    end

    // ----------------------------------------------------------------- fold
    hms_t folded_hms;
    logic fold_go;

    assign fold_go = fast_running && (pend_q_reg != 13'd0);

    sfck_fold u_fold (
        .cur_hms  (fast_hms_reg),
        .add_secs (pend_q_reg),
        .new_hms  (folded_hms)
    );

    // ---------------------------------------------------------- next state
    always_comb begin
        real_hms_next   = real_hms_reg;
        fast_hms_next   = fast_hms_reg;
        mode_next       = mode_reg;
        ratio_hund_next = ratio_hund_reg;
        ratio_dec_next  = ratio_dec_reg;
        ratio_unit_next = ratio_unit_reg;
        pend_q_next     = pend_q_reg;
        pend_r_next     = pend_r_reg;
        carry_next      = carry_reg;
        countdown_next  = countdown_reg;
        case (in_cmd)
            CMD_TICK: begin
                if (countdown_reg != 11'd0) begin
                    countdown_next = countdown_reg - 11'd1;
                end
                if (fast_running) begin
                    pend_q_next = tick_q;
                    pend_r_next = tick_r;
                    carry_next  = carry_left;
                end
            end
            CMD_SYNC: begin
                real_hms_next = in_real_hms;
                mode_next     = in_mode;
                if (in_has_fast) begin
                    fast_hms_next   = in_fast_hms;
                    ratio_hund_next = scale_hund;
                    ratio_dec_next  = scale_dec[3:0];
                    ratio_unit_next = scale_unit[3:0];
                end
                pend_q_next    = 13'd0;
                pend_r_next    = 4'd0;
                carry_next     = 5'd0;
                countdown_next = timeout_load(timeout_reg);
            end
            CMD_FOLD: begin
                // whole seconds fold in; the sub-second remainder stays
                if (fold_go) begin
                    fast_hms_next = folded_hms;
                    pend_q_next   = 13'd0;
                end
            end
            CMD_CLEAR: begin
                countdown_next = 11'd0;
            end
            default: begin
                countdown_next = countdown_reg;
            end
        endcase
    end

    // -------------------------------------------------------------- display
    disp_t      disp_state;
    logic [4:0] disp_hour;
    logic [5:0] disp_minute;
    mer_t       disp_mer;

    sfck_display u_display (
        .mode      (mode_next),
        .real_hms  (real_hms_next),
        .fast_hms  (fast_hms_next),
        .countdown (countdown_next),
        .state     (disp_state),
        .hour      (disp_hour),
        .minute    (disp_minute),
        .mer       (disp_mer)
    );

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[53:0];
            in_user_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_hms_reg   <= '0;
            fast_hms_reg   <= '0;
            mode_reg       <= '0;
            ratio_hund_reg <= 10'd0;    // ratio 10: one decisecond a tick
            ratio_dec_reg  <= 4'd1;
            ratio_unit_reg <= 4'd0;
            pend_q_reg     <= 13'd0;
            pend_r_reg     <= 4'd0;
            carry_reg      <= 5'd0;
            countdown_reg  <= 11'd0;
        end else if (advance) begin
            real_hms_reg   <= real_hms_next;
            fast_hms_reg   <= fast_hms_next;
            mode_reg       <= mode_next;
            ratio_hund_reg <= ratio_hund_next;
            ratio_dec_reg  <= ratio_dec_next;
            ratio_unit_reg <= ratio_unit_next;
            pend_q_reg     <= pend_q_next;
            pend_r_reg     <= pend_r_next;
            carry_reg      <= carry_next;
            countdown_reg  <= countdown_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {countdown_next, disp_mer, disp_minute, disp_hour};
            out_user_reg <= disp_state;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_carry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        carry_reg <= 5'(CARRY_LIMIT))
        else $error("tenths carry out of range");

    a_pend_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_r_reg < 4'(DECI_PER_SEC))
        else $error("pending remainder out of range");

    a_countdown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        countdown_reg <= TO_LOAD_120S)
        else $error("countdown above largest load");

    a_fold_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd == CMD_FOLD && fold_go) |=>
        (fast_hms_reg.seconds < 6'(SEC_PER_MIN) && fast_hms_reg.minutes < 6'(MIN_PER_HOUR)
         && fast_hms_reg.hours < 5'(HOURS_PER_DAY) && pend_q_reg == 13'd0))
        else $error("fold left fast time unnormalized");

    a_blank_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_user_reg == DISP_NONE || out_user_reg == DISP_HOLD))
        |-> (out_data_reg[12:0] == 13'd0))
        else $error("time shown while invalid or held");
`endif

endmodule
